@@ rtl/core/m4hdr_pkg.sv @@
`default_nettype none
package m4hdr_pkg;

    typedef enum logic [5:0] {
        S_HUNT, V_HEAD, V_OLI, V_VERID, V_PRIO, V_ASPECT, V_PAR, V_CTRL,
        V_CHROMA, V_LOWD, V_VBVF, V_VBV1, V_VBV2, V_VBV3, V_SHAPE, V_RES,
        V_MARK1, V_FIXED, V_FIXINC, V_MARK2, V_WIDTH, V_MARK3, V_HEIGHT, V_MARK4,
        V_INTER, V_OBMC, V_SPRITE, V_SPRDIM1, V_SPRDIM2, V_WARP, V_LLS, V_NOT8,
        V_QP, V_BPP, V_QTYPE, V_LDINTRA, V_MINTRA, V_LDINTER, V_MINTER, V_QPEL,
        V_CERS, V_PART, V_RVLC, V_NEWP, V_NEWPS, V_RRV, V_SCAL, V_SCALS,
        P_TYPE, P_MTB, P_MARK1, P_TINC, P_MARK2, P_CODED, P_ROUND, P_DC, P_IL,
        P_QUANT, P_FF, P_FB
    } pst_t;

    typedef enum logic {
        PH_RUN,
        PH_MOD
    } ph_t;

    typedef enum logic [1:0] {
        KIND_LAYER  = 2'd0,
        KIND_CODED  = 2'd1,
        KIND_SKIP   = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PRED_I = 2'd0,
        PRED_P = 2'd1,
        PRED_B = 2'd2,
        PRED_S = 2'd3
    } pred_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_q_t;

    localparam logic [31:0] LayerCode     = 32'h0000_0120;
    localparam logic [31:0] LayerMask     = 32'hFFFF_FFF0;
    localparam logic [31:0] PlaneCode     = 32'h0000_01B6;
    localparam logic [6:0]  MatrixLastPos = 7'd63;

    function automatic logic [5:0] dc_lookup(input logic [2:0] code);
        logic [5:0] r;
        unique case (code)
            3'd0: r = 6'd32;
            3'd1: r = 6'd13;
            3'd2: r = 6'd15;
            3'd3: r = 6'd17;
            3'd4: r = 6'd19;
            3'd5: r = 6'd21;
            3'd6: r = 6'd23;
            default: r = 6'd1;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/m4hdr_ifs.sv @@
`default_nettype none
interface m4hdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface m4hdr_cfg_if;
    logic valid;
    logic ready;
    logic freeze_times;
    modport source (output valid, output freeze_times, input ready);
    modport sink (input valid, input freeze_times, output ready);
endinterface

interface m4hdr_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [1:0]  pred_type;
    logic [8:0]  quantizer;
    logic [2:0]  fcode_fwd;
    logic [2:0]  fcode_bwd;
    logic        rounding;
    logic [5:0]  dc_threshold;
    logic [15:0] time_pp;
    logic [15:0] time_bp;
    logic [12:0] pic_width;
    logic [12:0] pic_height;
    logic [3:0]  unsupported;
    modport source (output valid, output record_kind, output pred_type, output quantizer,
                    output fcode_fwd, output fcode_bwd, output rounding,
                    output dc_threshold, output time_pp, output time_bp,
                    output pic_width, output pic_height, output unsupported,
                    input ready);
    modport sink (input valid, input record_kind, input pred_type, input quantizer,
                  input fcode_fwd, input fcode_bwd, input rounding,
                  input dc_threshold, input time_pp, input time_bp,
                  input pic_width, input pic_height, input unsupported,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/m4hdr_front.sv @@
`default_nettype none
module m4hdr_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    m4hdr_in_if.sink         din,
    output m4hdr_pkg::byte_q_t q,
    input  wire logic        pop
);
    import m4hdr_pkg::*;

    logic [7:0] mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       take;

    assign din.ready = (cnt_reg != 2'd2);
    assign push      = din.valid && din.ready;
    assign take      = pop && (cnt_reg != 2'd0);
    assign q.valid   = (cnt_reg != 2'd0);
    assign q.data    = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = take ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= din.data_byte;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/m4hdr_parser.sv @@
`default_nettype none
module m4hdr_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire m4hdr_pkg::byte_q_t q,
    output logic               pop,
    m4hdr_cfg_if.sink          cfg,
    m4hdr_rec_if.source        rec
);
    import m4hdr_pkg::*;

    pst_t        state_reg, state_next;
    ph_t         phase_reg, phase_next;
    logic [4:0]  pend_reg, pend_next;
    logic [15:0] accum_reg, accum_next;
    logic [7:0]  sh_reg, sh_next;
    logic [3:0]  left_reg, left_next;
    logic [31:0] window_reg, window_next;
    logic [15:0] res_reg, res_next;
    logic [4:0]  tbits_reg, tbits_next;
    logic [3:0]  qbits_reg, qbits_next;
    logic        il_reg, il_next;
    logic [1:0]  spr_reg, spr_next;
    logic [3:0]  ver_reg, ver_next;
    logic [15:0] lastref_reg, lastref_next;
    logic [15:0] tpp_reg, tpp_next;
    logic [15:0] tbp_reg, tbp_next;
    logic [6:0]  mpos_reg, mpos_next;
    logic        lowd_reg, lowd_next;
    logic [16:0] mrem_reg, mrem_next;
    logic [15:0] mdiv_reg, mdiv_next;
    logic        mneg_reg, mneg_next;
    logic        mbp_reg, mbp_next;
    logic [3:0]  mcnt_reg, mcnt_next;
    kind_t       kind_reg, kind_next;
    logic [1:0]  pred_reg, pred_next;
    logic        round_reg, round_next;
    logic [5:0]  dc_reg, dc_next;
    logic [2:0]  ff_reg, ff_next;
    logic [2:0]  fb_reg, fb_next;
    logic [3:0]  flags_reg, flags_next;
    logic [8:0]  quant_reg, quant_next;
    logic [12:0] w_reg, w_next;
    logic [12:0] h_reg, h_next;
    logic        ov_reg, ov_next;
    logic [1:0]  okind_reg, okind_next;
    logic [1:0]  opred_reg, opred_next;
    logic [8:0]  oquant_reg, oquant_next;
    logic [2:0]  off_reg, off_next;
    logic [2:0]  ofb_reg, ofb_next;
    logic        oround_reg, oround_next;
    logic [5:0]  odc_reg, odc_next;
    logic [15:0] otpp_reg, otpp_next;
    logic [15:0] otbp_reg, otbp_next;
    logic [12:0] ow_reg, ow_next;
    logic [12:0] oh_reg, oh_next;
    logic [3:0]  oflags_reg, oflags_next;

    logic [15:0] v;
    logic        emit;
    logic        hold;
    logic [16:0] step_rem;
    logic [16:0] diff;
    logic [15:0] res_new;
    logic [15:0] res_m1;
    logic [4:0]  nbits;
    logic [15:0] mod_out;
    logic        layer;
    logic        coded;

    assign cfg.ready = 1'b1;
    assign v         = accum_reg;

    always_comb
    begin
        res_new = (v != 16'd0) ? v : 16'd1;
        res_m1  = res_new - 16'd1;
        nbits   = 5'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (res_m1[i])
            begin
                nbits = 5'(i + 1);
            end
        end
        if (nbits == 5'd0)
        begin
            nbits = 5'd1;
        end
    end

    always_comb
    begin
        step_rem = {mrem_reg[15:0], mdiv_reg[mcnt_reg]};
        if (step_rem >= {1'b0, res_reg})
        begin
            step_rem = step_rem - {1'b0, res_reg};
        end
        mod_out = (mneg_reg && (step_rem != 17'd0)) ? (res_reg - step_rem[15:0])
                                                    : step_rem[15:0];
    end

    assign diff = (pred_reg != PRED_B) ? ({1'b0, v} - {1'b0, lastref_reg})
                                       : ({1'b0, lastref_reg} - {1'b0, v});

    assign hold = ov_reg && !rec.ready &&
                  (state_reg == V_SCAL || state_reg == V_SCALS || state_reg == P_CODED ||
                   state_reg == P_QUANT || state_reg == P_FF || state_reg == P_FB);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        pend_next    = pend_reg;
        accum_next   = accum_reg;
        sh_next      = sh_reg;
        left_next    = left_reg;
        window_next  = window_reg;
        res_next     = res_reg;
        tbits_next   = tbits_reg;
        qbits_next   = qbits_reg;
        il_next      = il_reg;
        spr_next     = spr_reg;
        ver_next     = ver_reg;
        lastref_next = lastref_reg;
        tpp_next     = tpp_reg;
        tbp_next     = tbp_reg;
        mpos_next    = mpos_reg;
        lowd_next    = (cfg.valid) ? cfg.freeze_times : lowd_reg;
        mrem_next    = mrem_reg;
        mdiv_next    = mdiv_reg;
        mneg_next    = mneg_reg;
        mbp_next     = mbp_reg;
        mcnt_next    = mcnt_reg;
        kind_next    = kind_reg;
        pred_next    = pred_reg;
        round_next   = round_reg;
        dc_next      = dc_reg;
        ff_next      = ff_reg;
        fb_next      = fb_reg;
        flags_next   = flags_reg;
        quant_next   = quant_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        pop          = 1'b0;
        emit         = 1'b0;

        if (phase_reg == PH_MOD)
        begin
            mrem_next = step_rem;
            mcnt_next = mcnt_reg - 4'd1;
            if (mcnt_reg == 4'd0)
            begin
                phase_next = PH_RUN;
                if (mbp_reg)
                begin
                    tbp_next = mod_out;
                end
                else
                begin
                    tpp_next = mod_out;
                end
            end
        end
        else if (state_reg == S_HUNT)
        begin
            if (q.valid)
            begin
                pop         = 1'b1;
                window_next = {window_reg[23:0], q.data};
                if ((window_next & LayerMask) == LayerCode)
                begin
                    kind_next = KIND_LAYER;
                    {pred_next, round_next, dc_next, ff_next, fb_next, flags_next} = '0;
                    {quant_next, w_next, h_next} = '0;
                    state_next = V_HEAD;
                    pend_next  = 5'd9;
                    accum_next = '0;
                end
                else if (window_next == PlaneCode)
                begin
                    kind_next = KIND_CODED;
                    {pred_next, round_next, dc_next, ff_next, fb_next, flags_next} = '0;
                    {quant_next, w_next, h_next} = '0;
                    state_next = P_TYPE;
                    pend_next  = 5'd2;
                    accum_next = '0;
                end
            end
        end
        else if (pend_reg != 5'd0)
        begin
            if (left_reg != 4'd0)
            begin
                accum_next = {accum_reg[14:0], sh_reg[7]};
                sh_next    = {sh_reg[6:0], 1'b0};
                left_next  = left_reg - 4'd1;
                pend_next  = pend_reg - 5'd1;
            end
            else if (q.valid)
            begin
                pop       = 1'b1;
                sh_next   = q.data;
                left_next = 4'd8;
            end
        end
        else if (!hold)
        begin
            accum_next = '0;
            unique case (state_reg)
                V_HEAD: begin state_next = V_OLI; pend_next = 5'd1; end
                V_OLI:
                begin
                    if (v != 16'd0)
                    begin
                        state_next = V_VERID; pend_next = 5'd4;
                    end
                    else
                    begin
                        ver_next = 4'd1; state_next = V_ASPECT; pend_next = 5'd4;
                    end
                end
                V_VERID:
                begin
                    ver_next = v[3:0]; state_next = V_PRIO; pend_next = 5'd3;
                end
                V_PRIO: begin state_next = V_ASPECT; pend_next = 5'd4; end
                V_ASPECT:
                begin
                    if (v == 16'd15)
                    begin
                        state_next = V_PAR; pend_next = 5'd16;
                    end
                    else
                    begin
                        state_next = V_CTRL; pend_next = 5'd1;
                    end
                end
                V_PAR: begin state_next = V_CTRL; pend_next = 5'd1; end
                V_CTRL:
                begin
                    if (v != 16'd0)
                    begin
                        state_next = V_CHROMA; pend_next = 5'd2;
                    end
                    else
                    begin
                        state_next = V_SHAPE; pend_next = 5'd3;
                    end
                end
                V_CHROMA: begin state_next = V_LOWD; pend_next = 5'd1; end
                V_LOWD: begin state_next = V_VBVF; pend_next = 5'd1; end
                V_VBVF:
                begin
                    if (v != 16'd0)
                    begin
                        state_next = V_VBV1; pend_next = 5'd31;
                    end
                    else
                    begin
                        state_next = V_SHAPE; pend_next = 5'd3;
                    end
                end
                V_VBV1: begin state_next = V_VBV2; pend_next = 5'd31; end
                V_VBV2: begin state_next = V_VBV3; pend_next = 5'd17; end
                V_VBV3: begin state_next = V_SHAPE; pend_next = 5'd3; end
                V_SHAPE: begin state_next = V_RES; pend_next = 5'd16; end
                V_RES:
                begin
                    res_next   = res_new;
                    tbits_next = nbits;
                    state_next = V_MARK1; pend_next = 5'd1;
                end
                V_MARK1: begin state_next = V_FIXED; pend_next = 5'd1; end
                V_FIXED:
                begin
                    if (v != 16'd0)
                    begin
                        state_next = V_FIXINC; pend_next = tbits_reg;
                    end
                    else
                    begin
                        state_next = V_MARK2; pend_next = 5'd1;
                    end
                end
                V_FIXINC: begin state_next = V_MARK2; pend_next = 5'd1; end
                V_MARK2: begin state_next = V_WIDTH; pend_next = 5'd13; end
                V_WIDTH:
                begin
                    w_next = v[12:0]; state_next = V_MARK3; pend_next = 5'd1;
                end
                V_MARK3: begin state_next = V_HEIGHT; pend_next = 5'd13; end
                V_HEIGHT:
                begin
                    h_next = v[12:0]; state_next = V_MARK4; pend_next = 5'd1;
                end
                V_MARK4: begin state_next = V_INTER; pend_next = 5'd1; end
                V_INTER:
                begin
                    il_next = v[0];
                    if (v != 16'd0)
                    begin
                        flags_next[0] = 1'b1;
                    end
                    state_next = V_OBMC; pend_next = 5'd1;
                end
                V_OBMC:
                begin
                    state_next = V_SPRITE;
                    pend_next  = (ver_reg == 4'd1) ? 5'd1 : 5'd2;
                end
                V_SPRITE:
                begin
                    spr_next = v[1:0];
                    if (v[1:0] == 2'd1)
                    begin
                        flags_next[1] = 1'b1; state_next = V_SPRDIM1; pend_next = 5'd28;
                    end
                    else if (v[1:0] == 2'd2)
                    begin
                        flags_next[1] = 1'b1; state_next = V_WARP; pend_next = 5'd9;
                    end
                    else
                    begin
                        state_next = V_NOT8; pend_next = 5'd1;
                    end
                end
                V_SPRDIM1: begin state_next = V_SPRDIM2; pend_next = 5'd28; end
                V_SPRDIM2: begin state_next = V_WARP; pend_next = 5'd9; end
                V_WARP:
                begin
                    if (spr_reg == 2'd1)
                    begin
                        state_next = V_LLS; pend_next = 5'd1;
                    end
                    else
                    begin
                        state_next = V_NOT8; pend_next = 5'd1;
                    end
                end
                V_LLS: begin state_next = V_NOT8; pend_next = 5'd1; end
                V_NOT8:
                begin
                    if (v != 16'd0)
                    begin
                        state_next = V_QP; pend_next = 5'd4;
                    end
                    else
                    begin
                        qbits_next = 4'd5; state_next = V_QTYPE; pend_next = 5'd1;
                    end
                end
                V_QP:
                begin
                    qbits_next = v[3:0]; state_next = V_BPP; pend_next = 5'd4;
                end
                V_BPP: begin state_next = V_QTYPE; pend_next = 5'd1; end
                V_QTYPE, V_LDINTER, V_MINTER:
                begin
                    if (state_reg == V_QTYPE && v != 16'd0)
                    begin
                        state_next = V_LDINTRA; pend_next = 5'd1;
                    end
                    else if (state_reg == V_LDINTER && v != 16'd0)
                    begin
                        mpos_next = '0; state_next = V_MINTER; pend_next = 5'd8;
                    end
                    else if (state_reg == V_MINTER && v != 16'd0 &&
                             mpos_reg != MatrixLastPos)
                    begin
                        mpos_next = mpos_reg + 7'd1; pend_next = 5'd8;
                    end
                    else if (ver_reg != 4'd1)
                    begin
                        state_next = V_QPEL; pend_next = 5'd1;
                    end
                    else
                    begin
                        state_next = V_CERS; pend_next = 5'd2;
                    end
                end
                V_LDINTRA:
                begin
                    if (v != 16'd0)
                    begin
                        mpos_next = '0; state_next = V_MINTRA; pend_next = 5'd8;
                    end
                    else
                    begin
                        state_next = V_LDINTER; pend_next = 5'd1;
                    end
                end
                V_MINTRA:
                begin
                    if (v != 16'd0 && mpos_reg != MatrixLastPos)
                    begin
                        mpos_next = mpos_reg + 7'd1; pend_next = 5'd8;
                    end
                    else
                    begin
                        state_next = V_LDINTER; pend_next = 5'd1;
                    end
                end
                V_QPEL:
                begin
                    if (v != 16'd0)
                    begin
                        flags_next[2] = 1'b1;
                    end
                    state_next = V_CERS; pend_next = 5'd2;
                end
                V_CERS: begin state_next = V_PART; pend_next = 5'd1; end
                V_PART, V_RVLC:
                begin
                    if (state_reg == V_PART && v != 16'd0)
                    begin
                        flags_next[3] = 1'b1; state_next = V_RVLC; pend_next = 5'd1;
                    end
                    else if (ver_reg != 4'd1)
                    begin
                        state_next = V_NEWP; pend_next = 5'd1;
                    end
                    else
                    begin
                        state_next = V_SCAL; pend_next = 5'd1;
                    end
                end
                V_NEWP:
                begin
                    if (v != 16'd0)
                    begin
                        state_next = V_NEWPS; pend_next = 5'd3;
                    end
                    else
                    begin
                        state_next = V_RRV; pend_next = 5'd1;
                    end
                end
                V_NEWPS: begin state_next = V_RRV; pend_next = 5'd1; end
                V_RRV: begin state_next = V_SCAL; pend_next = 5'd1; end
                V_SCAL:
                begin
                    if (v != 16'd0)
                    begin
                        state_next = V_SCALS; pend_next = 5'd27;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                V_SCALS: emit = 1'b1;
                P_TYPE:
                begin
                    pred_next = v[1:0]; state_next = P_MTB; pend_next = 5'd1;
                end
                P_MTB:
                begin
                    state_next = (v != 16'd0) ? P_MTB : P_MARK1; pend_next = 5'd1;
                end
                P_MARK1: begin state_next = P_TINC; pend_next = tbits_reg; end
                P_TINC:
                begin
                    if (!lowd_reg)
                    begin
                        phase_next = PH_MOD;
                        mcnt_next  = 4'd15;
                        mrem_next  = '0;
                        mneg_next  = diff[16];
                        mdiv_next  = diff[16] ? (16'd0 - diff[15:0]) : diff[15:0];
                        mbp_next   = (pred_reg == PRED_B);
                        if (pred_reg != PRED_B)
                        begin
                            lastref_next = v;
                        end
                    end
                    state_next = P_MARK2; pend_next = 5'd1;
                end
                P_MARK2: begin state_next = P_CODED; pend_next = 5'd1; end
                P_CODED:
                begin
                    if (v == 16'd0)
                    begin
                        kind_next = KIND_SKIP; emit = 1'b1;
                    end
                    else if (pred_reg == PRED_P || pred_reg == PRED_S)
                    begin
                        state_next = P_ROUND; pend_next = 5'd1;
                    end
                    else
                    begin
                        state_next = P_DC; pend_next = 5'd3;
                    end
                end
                P_ROUND:
                begin
                    round_next = v[0]; state_next = P_DC; pend_next = 5'd3;
                end
                P_DC:
                begin
                    dc_next = dc_lookup(v[2:0]);
                    if (il_reg)
                    begin
                        state_next = P_IL; pend_next = 5'd2;
                    end
                    else
                    begin
                        state_next = P_QUANT; pend_next = {1'b0, qbits_reg};
                    end
                end
                P_IL: begin state_next = P_QUANT; pend_next = {1'b0, qbits_reg}; end
                P_QUANT:
                begin
                    quant_next = (v > 16'd511) ? 9'd511 : v[8:0];
                    if (pred_reg != PRED_I)
                    begin
                        state_next = P_FF; pend_next = 5'd3;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                P_FF:
                begin
                    ff_next = v[2:0];
                    if (pred_reg == PRED_B)
                    begin
                        state_next = P_FB; pend_next = 5'd3;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                P_FB: begin fb_next = v[2:0]; emit = 1'b1; end
                default: begin state_next = S_HUNT; pend_next = 5'd1; end
            endcase
            if (emit)
            begin
                state_next  = S_HUNT;
                pend_next   = 5'd0;
                left_next   = 4'd0;
                window_next = '1;
            end
        end
    end

    assign layer = (kind_next == KIND_LAYER);
    assign coded = (kind_next == KIND_CODED);

    always_comb
    begin
        ov_next     = ov_reg && !rec.ready;
        okind_next  = okind_reg;
        opred_next  = opred_reg;
        oquant_next = oquant_reg;
        off_next    = off_reg;
        ofb_next    = ofb_reg;
        oround_next = oround_reg;
        odc_next    = odc_reg;
        otpp_next   = otpp_reg;
        otbp_next   = otbp_reg;
        ow_next     = ow_reg;
        oh_next     = oh_reg;
        oflags_next = oflags_reg;
        if (emit)
        begin
            ov_next     = 1'b1;
            okind_next  = kind_next;
            opred_next  = layer ? 2'd0 : pred_next;
            oquant_next = coded ? quant_next : 9'd0;
            off_next    = coded ? ff_next : 3'd0;
            ofb_next    = coded ? fb_next : 3'd0;
            oround_next = coded ? round_next : 1'b0;
            odc_next    = coded ? dc_next : 6'd0;
            otpp_next   = layer ? 16'd0 : tpp_reg;
            otbp_next   = layer ? 16'd0 : tbp_reg;
            ow_next     = layer ? w_next : 13'd0;
            oh_next     = layer ? h_next : 13'd0;
            oflags_next = layer ? flags_next : 4'd0;
        end
    end

    assign rec.valid        = ov_reg;
    assign rec.record_kind  = okind_reg;
    assign rec.pred_type    = opred_reg;
    assign rec.quantizer    = oquant_reg;
    assign rec.fcode_fwd    = off_reg;
    assign rec.fcode_bwd    = ofb_reg;
    assign rec.rounding     = oround_reg;
    assign rec.dc_threshold = odc_reg;
    assign rec.time_pp      = otpp_reg;
    assign rec.time_bp      = otbp_reg;
    assign rec.pic_width    = ow_reg;
    assign rec.pic_height   = oh_reg;
    assign rec.unsupported  = oflags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_HUNT;
            phase_reg   <= PH_RUN;
            pend_reg    <= '0;
            accum_reg   <= '0;
            left_reg    <= '0;
            window_reg  <= '1;
            res_reg     <= 16'd1;
            tbits_reg   <= '0;
            qbits_reg   <= 4'd5;
            il_reg      <= 1'b0;
            spr_reg     <= '0;
            ver_reg     <= 4'd1;
            lastref_reg <= '0;
            tpp_reg     <= '0;
            tbp_reg     <= '0;
            mpos_reg    <= '0;
            lowd_reg    <= 1'b0;
            mcnt_reg    <= '0;
            kind_reg    <= KIND_LAYER;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pend_reg    <= pend_next;
            accum_reg   <= accum_next;
            left_reg    <= left_next;
            window_reg  <= window_next;
            res_reg     <= res_next;
            tbits_reg   <= tbits_next;
            qbits_reg   <= qbits_next;
            il_reg      <= il_next;
            spr_reg     <= spr_next;
            ver_reg     <= ver_next;
            lastref_reg <= lastref_next;
            tpp_reg     <= tpp_next;
            tbp_reg     <= tbp_next;
            mpos_reg    <= mpos_next;
            lowd_reg    <= lowd_next;
            mcnt_reg    <= mcnt_next;
            kind_reg    <= kind_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg     <= sh_next;
        mrem_reg   <= mrem_next;
        mdiv_reg   <= mdiv_next;
        mneg_reg   <= mneg_next;
        mbp_reg    <= mbp_next;
        pred_reg   <= pred_next;
        round_reg  <= round_next;
        dc_reg     <= dc_next;
        ff_reg     <= ff_next;
        fb_reg     <= fb_next;
        flags_reg  <= flags_next;
        quant_reg  <= quant_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        okind_reg  <= okind_next;
        opred_reg  <= opred_next;
        oquant_reg <= oquant_next;
        off_reg    <= off_next;
        ofb_reg    <= ofb_next;
        oround_reg <= oround_next;
        odc_reg    <= odc_next;
        otpp_reg   <= otpp_next;
        otbp_reg   <= otbp_next;
        ow_reg     <= ow_next;
        oh_reg     <= oh_next;
        oflags_reg <= oflags_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/mpeg4_vol_vop_header_parser_core.sv @@
`default_nettype none
// Channel  Role    Payload
// din      sink    data_byte, one stream byte per transfer
// cfg      sink    freeze_times, always ready
// rec      source  one header record per transfer
//
// A byte in a header is loaded from the two-entry byte queue and then
// shifted bit by bit through the serial field extractor; every finished
// field takes a further step. A byte seen while hunting goes into the start-code window.
// Unless freeze_times is set, a plane time increment also runs through the remainder unit.
// Reset returns the parser to hunting; the record register holds while rec stalls.
module mpeg4_vol_vop_header_parser_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    m4hdr_in_if.sink    din,
    m4hdr_cfg_if.sink   cfg,
    m4hdr_rec_if.source rec
);
    import m4hdr_pkg::*;

    byte_q_t q;
    logic    pop;

    m4hdr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .q     (q),
        .pop   (pop)
    );

    m4hdr_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .q     (q),
        .pop   (pop),
        .cfg   (cfg),
        .rec   (rec)
    );

endmodule
`default_nettype wire
